### hdl/bsqp_pkg.sv
// Package for the BF16 scalar quantizer and packer.
// Holds commands, sizes, queue entry type and BF16 compare helpers. No dependencies.
package bsqp_pkg;

  localparam int unsigned MAX_LEVELS_DEF = 256;
  localparam int unsigned MAX_DIM_DEF    = 128;

  typedef enum logic [1:0] {
    CMD_QUANT  = 2'd0,
    CMD_WR_BND = 2'd1,
    CMD_WR_CEN = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  localparam logic CFG_IDX_WIDTH = 1'b0;
  localparam logic CFG_IDX_VLEN  = 1'b1;

  // Back part sequencing: take, boundary walk, centroid read, hold result
  typedef enum logic [1:0] {
    ST_IDLE, ST_SRCH, ST_CEN, ST_OUT
  } st_t;

  // Request handed from the front part to the back part
  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  entry_index;
    logic [15:0] table_word;
    logic [15:0] sample;
  } req_t;

  function automatic logic bf16_is_nan(input logic [15:0] w);
    return w[14:0] > 15'h7F80;
  endfunction

  // Float order with -0 == +0; NaN never exceeds
  function automatic logic bf16_greater(input logic [15:0] a, input logic [15:0] b);
    logic signed [16:0] ka;
    logic signed [16:0] kb;
    ka = a[15] ? -$signed({2'b00, a[14:0]}) : $signed({2'b00, a[14:0]});
    kb = b[15] ? -$signed({2'b00, b[14:0]}) : $signed({2'b00, b[14:0]});
    return !bf16_is_nan(a) && !bf16_is_nan(b) && (ka > kb);
  endfunction

endpackage

### hdl/bsqp_front.sv
// Front part: accepts requests into a two-entry queue toward the back part.
// Depends on bsqp_pkg.
module bsqp_front
  import bsqp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  req_t in_req,
  output logic q_valid,
  output req_t q_req,
  input  logic q_take
);

  req_t       buf_r [2];
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;

  assign in_full = cnt_r == 2'd2;
  assign do_push = in_push && !in_full;
  assign q_valid = cnt_r != 2'd0;
  assign q_req   = buf_r[rd_r];

  // Advance pointers and count
  always_comb begin
    rd_nxt  = rd_r ^ (q_take && q_valid);
    wr_nxt  = wr_r ^ do_push;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, q_take && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wr_r] <= in_req;
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_full && !(q_take && q_valid)) |=> cnt_r == 2'd2)
    else $error("count changed while full");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> rd_r == wr_r)
    else $error("pointer mismatch");

endmodule

### hdl/bsqp_back.sv
// Back part: boundary search over a shared compare, centroid lookup and packing.
// Depends on bsqp_pkg; holds the boundary and centroid memories.
module bsqp_back
  import bsqp_pkg::*;
#(
  parameter int unsigned MAX_LEVELS = MAX_LEVELS_DEF,
  parameter int unsigned MAX_DIM    = MAX_DIM_DEF
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  req_t        q_req,
  output logic        q_take,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [7:0]  cfg_data,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [7:0]  out_level_index,
  output logic [15:0] out_centroid_value,
  output logic        out_byte_ready,
  output logic [7:0]  out_packed_byte,
  output logic        out_vector_end
);

  localparam int unsigned LW = $clog2(MAX_LEVELS);
  localparam int unsigned BW = (MAX_LEVELS > 2) ? $clog2(MAX_LEVELS - 1) : 1;
  localparam int unsigned DW = $clog2(MAX_DIM + 1);

  logic [15:0] bnd_mem [MAX_LEVELS-1];
  logic [15:0] cen_mem [MAX_LEVELS];
  logic [15:0] bnd_q, cen_q;

  st_t         st_r, st_nxt;
  logic [1:0]  wcode_r;
  logic [7:0]  vlen_r;
  logic [15:0] smp_r;
  logic [8:0]  idx_r;
  logic [DW-1:0] ccnt_r;
  logic [7:0]  acc_r;
  logic [2:0]  slot_r;
  logic [8:0]  nb;
  logic [3:0]  bits;
  logic [DW-1:0] len;
  logic        gt, stop, last, full;
  logic [7:0]  acc_new;
  logic [3:0]  slots_per_byte;
  logic        bnd_rd_en;
  logic [8:0]  rd_addr;

  // Derive the number of boundaries, vector length and slots per byte from config
  always_comb begin
    bits = 4'd1 << wcode_r;
    nb   = (bits == 4'd8 || (9'd1 << bits) > 9'(MAX_LEVELS))
         ? 9'(MAX_LEVELS - 1) : (9'd1 << bits) - 9'd1;
    if (vlen_r == 8'd0) len = DW'(1);
    else if (32'(vlen_r) > MAX_DIM) len = DW'(MAX_DIM);
    else len = DW'(vlen_r);
    slots_per_byte = 4'd8 >> wcode_r;
  end

  assign gt   = bf16_greater(smp_r, bnd_q);
  assign stop = (idx_r >= nb) || !gt;
  assign q_take = (st_r == ST_IDLE) && q_valid &&
                  (q_req.cmd != CMD_QUANT || out_empty);

  // Boundary read address: next entry to compare
  assign rd_addr = (st_r == ST_IDLE) ? 9'd0 : idx_r + 9'd1;
  assign bnd_rd_en = (st_r == ST_IDLE && q_take && q_req.cmd == CMD_QUANT) ||
                     (st_r == ST_SRCH && !stop);

  // Table writes and registered reads
  always_ff @(posedge clk) begin
    if (q_take && q_req.cmd == CMD_WR_BND && 32'(q_req.entry_index) < MAX_LEVELS - 1)
      bnd_mem[q_req.entry_index[BW-1:0]] <= q_req.table_word;
    if (q_take && q_req.cmd == CMD_WR_CEN && 32'(q_req.entry_index) < MAX_LEVELS)
      cen_mem[q_req.entry_index[LW-1:0]] <= q_req.table_word;
    if (bnd_rd_en && 32'(rd_addr) < MAX_LEVELS - 1)
      bnd_q <= bnd_mem[rd_addr[BW-1:0]];
    if (st_r == ST_SRCH && stop)
      cen_q <= cen_mem[idx_r[LW-1:0]];
  end

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (q_take && q_req.cmd == CMD_QUANT) st_nxt = ST_SRCH;
      ST_SRCH: if (stop) st_nxt = ST_CEN;
      ST_CEN:  st_nxt = ST_OUT;
      ST_OUT:  if (out_pop) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Packing arithmetic for the finished sample
  always_comb begin
    acc_new = acc_r | 8'(idx_r[7:0] << ((slot_r * 3'(bits)) & 3'd7));
    last    = (ccnt_r + DW'(1)) >= len;
    full    = ({1'b0, slot_r} + 4'd1) >= slots_per_byte;
  end

  assign out_empty = st_r != ST_OUT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      wcode_r <= 2'd2;
      vlen_r  <= 8'd128;
      ccnt_r  <= '0;
      acc_r   <= 8'd0;
      slot_r  <= 3'd0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        if (cfg_idx == CFG_IDX_WIDTH) wcode_r <= cfg_data[1:0];
        else vlen_r <= cfg_data;
        ccnt_r <= '0;
        acc_r  <= 8'd0;
        slot_r <= 3'd0;
      end else if (st_r == ST_CEN) begin
        acc_r  <= (full || last) ? 8'd0 : acc_new;
        slot_r <= (full || last) ? 3'd0 : slot_r + 3'd1;
        ccnt_r <= last ? '0 : ccnt_r + DW'(1);
      end
    end
  end

  // Search and result registers
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && q_take) begin
      smp_r <= q_req.sample;
      idx_r <= 9'd0;
    end else if (st_r == ST_SRCH && !stop) begin
      idx_r <= idx_r + 9'd1;
    end
    if (st_r == ST_CEN) begin
      out_level_index    <= idx_r[7:0];
      out_centroid_value <= cen_q;
      out_byte_ready     <= full || last;
      out_packed_byte    <= (full || last) ? acc_new : 8'd0;
      out_vector_end     <= last;
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_SRCH |-> idx_r <= nb)
    else $error("index past boundary count");
  a_pack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_byte_ready) |-> out_packed_byte == 8'd0)
    else $error("packed byte without ready");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT && !out_pop) |=> st_r == ST_OUT)
    else $error("result dropped");

endmodule

### hdl/bf16_scalar_quantizer_packer_top.sv
// Top level of the BF16 scalar quantizer and packer.
// Depends on bsqp_pkg, bsqp_front and bsqp_back.
//
//  channel  | handshake       | payload
//  in_      | push / full     | cmd, entry_index, table_word, sample
//  out_     | pop / empty     | level_index, centroid_value, byte_ready, packed_byte, vector_end
//  cfg_     | we              | idx, data
//
// After a sample is taken, the back part walks the boundaries it exceeds, reads its
// centroid as the search stops, registers the result and holds it until it is popped.
// One shared comparator walks the boundary memory.
// Reset is synchronous, active low; the tables hold garbage until written.
// A held result stalls every further request; the two-entry queue keeps taking requests until full.
module bf16_scalar_quantizer_packer_top
  import bsqp_pkg::*;
#(
  parameter int unsigned MAX_LEVELS = MAX_LEVELS_DEF,
  parameter int unsigned MAX_DIM    = MAX_DIM_DEF
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_entry_index,
  input  logic [15:0] in_table_word,
  input  logic [15:0] in_sample,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_level_index,
  output logic [15:0] out_centroid_value,
  output logic        out_byte_ready,
  output logic [7:0]  out_packed_byte,
  output logic        out_vector_end,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [7:0]  cfg_data
);

  req_t in_req, q_req;
  logic q_valid, q_take;

  assign in_req = '{cmd: cmd_t'(in_cmd), entry_index: in_entry_index,
                    table_word: in_table_word, sample: in_sample};

  bsqp_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_req,
    .q_valid, .q_req, .q_take
  );

  bsqp_back #(.MAX_LEVELS(MAX_LEVELS), .MAX_DIM(MAX_DIM)) u_back (
    .clk, .rst_n, .q_valid, .q_req, .q_take,
    .cfg_we, .cfg_idx, .cfg_data,
    .out_pop, .out_empty, .out_level_index, .out_centroid_value,
    .out_byte_ready, .out_packed_byte, .out_vector_end
  );

endmodule
